[rtl/tcpar_pkg.sv]
// ----------------------------------------------------------------------------
// tcpar_pkg
// Shared types and constants for the telecommand acceptance and routing check.
// ----------------------------------------------------------------------------
package tcpar_pkg;

    // Input item: one packet byte with its final-byte mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // Result item: one verdict per packet
    typedef struct packed {
        logic [2:0]  verdict;
        logic [3:0]  route_index;
        logic [7:0]  service_kind;
        logic [16:0] packet_bytes;
    } t_out_item;

    // Captured header fields, byte count and running CRC of one packet
    typedef struct packed {
        logic [16:0] byte_count;
        logic [3:0]  version_and_flag;
        logic [1:0]  sequence_bits;
        logic [15:0] length_field;
        logic [3:0]  pus_version;
        logic [7:0]  service;
        logic [15:0] crc;
    } t_pkt_status;

    // Service lookup outcome
    typedef struct packed {
        logic       found;
        logic [3:0] index;
    } t_route_result;

    // Verdict codes
    localparam logic [2:0] VERDICT_ROUTED       = 3'd0;
    localparam logic [2:0] VERDICT_UNACCEPTABLE = 3'd1;
    localparam logic [2:0] VERDICT_ILLEGAL_APP  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_CRC      = 3'd3;
    localparam logic [2:0] VERDICT_ILLEGAL_TYPE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SERVICE_COUNT = 2'd0;
    localparam logic [1:0] CFG_TYPES_LOW     = 2'd1;
    localparam logic [1:0] CFG_TYPES_HIGH    = 2'd2;

    // Packet format constants
    localparam logic [16:0] COUNT_LIMIT    = 17'd65542;
    localparam logic [16:0] LENGTH_OFFSET  = 17'd7;
    localparam logic [1:0]  SEQ_STANDALONE = 2'd3;
    localparam logic [3:0]  PUS_VERSION    = 4'd2;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    localparam t_pkt_status PKT_CLEAR = '{
        byte_count:       17'd0,
        version_and_flag: 4'd0,
        sequence_bits:    2'd0,
        length_field:     16'd0,
        pus_version:      4'd0,
        service:          8'd0,
        crc:              CRC_INIT
    };

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/tc_packet_accept_and_route.sv]
// ----------------------------------------------------------------------------
// tc_packet_accept_and_route
// Telecommand packet acceptance check with service routing.
// ----------------------------------------------------------------------------
// The block takes one packet byte per item and accepts a new byte every clock
// cycle while the input is not stalled; a byte is registered at the input,
// then counted, captured and folded into the CRC as it leaves that register,
// so the combinational CRC-16 byte update and the field capture set the rate
// of one byte per cycle. Non-final bytes give no result. On the final byte one
// result item is loaded into the output register as that byte leaves the input
// register, carrying the verdict (unacceptable packet, illegal application
// data, bad checksum, illegal packet type, checked in that order, else routed),
// the route slot, the service type byte and the saturating byte count. The
// output register lets input bytes keep flowing while a result waits; the input
// stalls only when a final byte reaches processing while an earlier result is
// still held. Configuration registers are written through a separate port
// that is always ready; write them only while no packet is in progress.
// ----------------------------------------------------------------------------
module tc_packet_accept_and_route
    import tcpar_pkg::*;
#(
    parameter int MAX_SERVICES     = 16,
    parameter int MIN_PACKET_BYTES = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Configuration registers
    logic [3:0]  r_service_count;
    logic [63:0] r_types_low;
    logic [63:0] r_types_high;

    // Input register
    logic        r_in_valid;
    t_in_item    r_in;

    // Output register
    logic        r_out_valid;
    t_out_item   r_out;

    logic          out_free;
    logic          consume;
    t_pkt_status   pkt_next;
    t_route_result route;
    t_out_item     n_out;
    logic          short_pkt;
    logic          hdr_bad;

    // ------------------------------------------------------------------
    // Configuration: always ready, unknown indexes dropped
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_count <= 4'd0;
            r_types_low     <= 64'd0;
            r_types_high    <= 64'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SERVICE_COUNT: r_service_count <= i_cfg_data[3:0];
                CFG_TYPES_LOW:     r_types_low     <= i_cfg_data;
                CFG_TYPES_HIGH:    r_types_high    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a non-final byte always advances; a final byte needs
    // the output register free (empty or being drained this cycle)
    // ------------------------------------------------------------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign consume    = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_valid && !consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // ------------------------------------------------------------------
    // Packet tracking and service lookup
    // ------------------------------------------------------------------
    tcpar_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_byte  (r_in.data_byte),
        .i_last  (r_in.last_byte),
        .o_next  (pkt_next)
    );

    tcpar_route #(
        .MAX_SERVICES (MAX_SERVICES)
    ) u_route (
        .i_service_count (r_service_count),
        .i_types_low     (r_types_low),
        .i_types_high    (r_types_high),
        .i_service       (pkt_next.service),
        .o_route         (route)
    );

    // ------------------------------------------------------------------
    // Verdict, checks in priority order on the values after this byte
    // ------------------------------------------------------------------
    assign short_pkt = pkt_next.byte_count < 17'(MIN_PACKET_BYTES);
    assign hdr_bad   = (pkt_next.version_and_flag[3:1] != 3'd0)
                    || !pkt_next.version_and_flag[0]
                    || (pkt_next.sequence_bits != SEQ_STANDALONE)
                    || ({1'b0, pkt_next.length_field}
                        != (pkt_next.byte_count - LENGTH_OFFSET));

    always_comb begin
        n_out              = '0;
        n_out.service_kind = pkt_next.service;
        n_out.packet_bytes = pkt_next.byte_count;
        if (short_pkt || hdr_bad) begin
            n_out.verdict = VERDICT_UNACCEPTABLE;
        end else if (pkt_next.pus_version != PUS_VERSION) begin
            n_out.verdict = VERDICT_ILLEGAL_APP;
        end else if (pkt_next.crc != 16'd0) begin
            n_out.verdict = VERDICT_BAD_CRC;
        end else if (!route.found) begin
            n_out.verdict = VERDICT_ILLEGAL_TYPE;
        end else begin
            n_out.verdict     = VERDICT_ROUTED;
            n_out.route_index = route.index;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on a final byte, drop when taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_route_zero_unless_routed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.verdict != VERDICT_ROUTED)
            |-> (o_out_item.route_index == 4'd0))
        else $error("route index set on a rejected packet");

    a_routed_not_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.verdict == VERDICT_ROUTED)
            |-> (o_out_item.packet_bytes >= 17'(MIN_PACKET_BYTES)))
        else $error("short packet routed");

    a_empty_input_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with an empty input register");

    a_final_byte_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in.last_byte) |=> o_out_valid)
        else $error("final byte processed without a result");

endmodule

[rtl/tcpar_track.sv]
// ----------------------------------------------------------------------------
// tcpar_track
// Per-packet byte counter, header field capture and running CRC.
// ----------------------------------------------------------------------------
module tcpar_track
    import tcpar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_pkt_status o_next
);

    localparam logic [16:0] POS_VERSION  = 17'd0;
    localparam logic [16:0] POS_SEQUENCE = 17'd2;
    localparam logic [16:0] POS_LEN_HIGH = 17'd4;
    localparam logic [16:0] POS_LEN_LOW  = 17'd5;
    localparam logic [16:0] POS_PUS      = 17'd6;
    localparam logic [16:0] POS_SERVICE  = 17'd7;

    t_pkt_status r_stat;
    t_pkt_status n_stat;

    always_comb begin
        n_stat = r_stat;
        case (r_stat.byte_count)
            POS_VERSION:  n_stat.version_and_flag = {i_byte[7:5], i_byte[3]};
            POS_SEQUENCE: n_stat.sequence_bits    = i_byte[7:6];
            POS_LEN_HIGH: n_stat.length_field     = {i_byte, 8'h00};
            POS_LEN_LOW:  n_stat.length_field     = {r_stat.length_field[15:8], i_byte};
            POS_PUS:      n_stat.pus_version      = i_byte[7:4];
            POS_SERVICE:  n_stat.service          = i_byte;
            default:      ;
        endcase
        n_stat.crc = crc16_byte(r_stat.crc, i_byte);
        if (r_stat.byte_count < COUNT_LIMIT) begin
            n_stat.byte_count = r_stat.byte_count + 17'd1;
        end
    end

    assign o_next = n_stat;

    // Clear for the next packet once the final byte is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat <= PKT_CLEAR;
        end else if (i_step) begin
            r_stat <= i_last ? PKT_CLEAR : n_stat;
        end
    end

endmodule

[rtl/tcpar_route.sv]
// ----------------------------------------------------------------------------
// tcpar_route
// Service type lookup: lowest configured slot whose type matches.
// ----------------------------------------------------------------------------
module tcpar_route
    import tcpar_pkg::*;
#(
    parameter int MAX_SERVICES = 16
) (
    input  logic [3:0]    i_service_count,
    input  logic [63:0]   i_types_low,
    input  logic [63:0]   i_types_high,
    input  logic [7:0]    i_service,
    output t_route_result o_route
);

    logic [15:0][7:0] types;

    assign types = {i_types_high, i_types_low};

    // Scan downward so the lowest matching slot is left standing
    always_comb begin
        o_route = '0;
        for (int s = MAX_SERVICES - 1; s >= 0; s--) begin
            if ({1'b0, i_service_count} > 5'(s) && types[s] == i_service) begin
                o_route.found = 1'b1;
                o_route.index = 4'(s);
            end
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telecommand acceptance and routing check:
// planned packets stream in byte by byte under bursty traffic, every byte is
// folded into a local verdict predictor, and each verdict that leaves the
// block is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
    import tcpar_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 1000;
    localparam int RANDOM_PACKETS = 40;
    localparam int PHASE_BYTES    = 150;
    localparam int MAX_SLOTS      = 16;
    localparam int MIN_BYTES      = 13;
    localparam int MAX_REPORTS    = 40;
    localparam longint RUN_LIMIT_NS = 20_000_000;

    // register index the block does not map; writes to it must be ignored
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    // header defects a planned packet can carry, combinable
    localparam logic [5:0] FLAW_NONE     = 6'b000000;
    localparam logic [5:0] FLAW_VERSION  = 6'b000001;
    localparam logic [5:0] FLAW_SEC_FLAG = 6'b000010;
    localparam logic [5:0] FLAW_SEQUENCE = 6'b000100;
    localparam logic [5:0] FLAW_LENGTH   = 6'b001000;
    localparam logic [5:0] FLAW_PUS      = 6'b010000;
    localparam logic [5:0] FLAW_CRC      = 6'b100000;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCKED} t_rx_style;

    // ------------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_SERVICE_COUNT;
    logic [63:0] i_cfg_data  = '0;

    tc_packet_accept_and_route #(
        .MAX_SERVICES     (MAX_SLOTS),
        .MIN_PACKET_BYTES (MIN_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Verdict predictor: its own copy of the routing table and packet state
    // ------------------------------------------------------------------------
    logic [16:0] seen_bytes;
    logic [3:0]  hdr_version_flag;   // version in [3:1], secondary-header flag in [0]
    logic [1:0]  hdr_sequence;
    logic [15:0] hdr_length;
    logic [3:0]  hdr_pus;
    logic [7:0]  hdr_service;
    logic [15:0] running_crc;
    logic [3:0]  route_slots_used;
    logic [7:0]  route_table [MAX_SLOTS];

    t_out_item   expected_verdicts [$];

    int fail_count     = 0;
    int checked_count  = 0;
    int bytes_accepted = 0;
    int cfg_writes     = 0;
    int verdict_tally [5] = '{default: 0};

    // Bit-serial CRC-16-CCITT, MSB first
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb  = crc[15] ^ b[k];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    task automatic restart_packet();
        seen_bytes       = '0;
        hdr_version_flag = '0;
        hdr_sequence     = '0;
        hdr_length       = '0;
        hdr_pus          = '0;
        hdr_service      = '0;
        running_crc      = CRC_INIT;
    endtask

    // Fold one accepted byte into the packet state; on the final byte queue the verdict.
    task automatic track_byte(input t_in_item it);
        t_out_item   v;
        logic [16:0] n;
        logic        hit;
        case (seen_bytes)
            17'd0: hdr_version_flag = {it.data_byte[7:5], it.data_byte[3]};
            17'd2: hdr_sequence = it.data_byte[7:6];
            17'd4: hdr_length[15:8] = it.data_byte;
            17'd5: hdr_length[7:0] = it.data_byte;
            17'd6: hdr_pus = it.data_byte[7:4];
            17'd7: hdr_service = it.data_byte;
            default: ;
        endcase
        running_crc = crc_ccitt_step(running_crc, it.data_byte);
        if (seen_bytes < COUNT_LIMIT) begin
            seen_bytes = seen_bytes + 17'd1;
        end
        if (it.last_byte) begin
            n              = seen_bytes;
            v              = '0;
            v.service_kind = hdr_service;
            v.packet_bytes = n;
            if (n < 17'(MIN_BYTES)) begin
                v.verdict = VERDICT_UNACCEPTABLE;
            end else if (hdr_version_flag[3:1] != 3'd0 || !hdr_version_flag[0] ||
                         hdr_sequence != SEQ_STANDALONE ||
                         {1'b0, hdr_length} != n - LENGTH_OFFSET) begin
                v.verdict = VERDICT_UNACCEPTABLE;
            end else if (hdr_pus != PUS_VERSION) begin
                v.verdict = VERDICT_ILLEGAL_APP;
            end else if (running_crc != 16'h0000) begin
                v.verdict = VERDICT_BAD_CRC;
            end else begin
                // lowest matching slot among the enabled ones wins
                hit = 1'b0;
                for (int s = 0; s < MAX_SLOTS; s++) begin
                    if (!hit && s < int'(route_slots_used) &&
                        route_table[s] == hdr_service) begin
                        hit           = 1'b1;
                        v.route_index = 4'(s);
                    end
                end
                v.verdict = hit ? VERDICT_ROUTED : VERDICT_ILLEGAL_TYPE;
            end
            expected_verdicts.push_back(v);
            restart_packet();
        end
    endtask

    // ------------------------------------------------------------------------
    // Input-side monitor: track accepted bytes and register writes at the edge
    // ------------------------------------------------------------------------
    logic byte_taken = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_packet();
            route_slots_used = '0;
            foreach (route_table[s]) route_table[s] = 8'h00;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                track_byte(i_in_item);
                bytes_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SERVICE_COUNT: route_slots_used = i_cfg_data[3:0];
                    CFG_TYPES_LOW: begin
                        for (int s = 0; s < 8; s++) route_table[s] = i_cfg_data[s*8 +: 8];
                    end
                    CFG_TYPES_HIGH: begin
                        for (int s = 0; s < 8; s++) route_table[s+8] = i_cfg_data[s*8 +: 8];
                    end
                    default: ;  // unmapped index: drop the write
                endcase
            end
        end
        byte_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // ------------------------------------------------------------------------
    // Byte driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    t_in_item byte_plan [$];
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            // current item gone (or none): pause, advance, or go quiet
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (byte_plan.size() > 0) begin
                i_in_item  <= byte_plan.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    // long stretch at full rate
                    burst_left = $urandom_range(50, 300);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 20)
                                                             : $urandom_range(0, 5);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall in segments of varying style
    // ------------------------------------------------------------------------
    t_rx_style rx_style = RX_FREE;
    int        rx_left  = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_left  = $urandom_range(4, 60);
            rx_style = t_rx_style'($urandom_range(0, 3));
        end else begin
            rx_left--;
        end
        case (rx_style)
            RX_FREE:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:  i_out_stall <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string detail);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on verdict %0d: %s", $time, checked_count, detail);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %0d with no packet pending",
                                          o_out_item.verdict));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_out_item.verdict !== want.verdict)
                    report_mismatch($sformatf("verdict got %0d want %0d",
                                              o_out_item.verdict, want.verdict));
                if (o_out_item.route_index !== want.route_index)
                    report_mismatch($sformatf("route_index got %0d want %0d",
                                              o_out_item.route_index, want.route_index));
                if (o_out_item.service_kind !== want.service_kind)
                    report_mismatch($sformatf("service_kind got %0d want %0d",
                                              o_out_item.service_kind, want.service_kind));
                if (o_out_item.packet_bytes !== want.packet_bytes)
                    report_mismatch($sformatf("packet_bytes got %0d want %0d",
                                              o_out_item.packet_bytes, want.packet_bytes));
                if (want.verdict <= VERDICT_ILLEGAL_TYPE) verdict_tally[want.verdict]++;
            end
            checked_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------------
    logic [7:0] plan_slots [MAX_SLOTS];
    int         plan_used    = 0;
    int         plan_bytes   = 0;
    int         plan_packets = 0;

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Write the planned routing table; junk the unused upper bits of the count.
    task automatic commit_routes();
        logic [63:0] lo, hi, cnt;
        for (int s = 0; s < 8; s++) begin
            lo[s*8 +: 8] = plan_slots[s];
            hi[s*8 +: 8] = plan_slots[s+8];
        end
        cnt = {$urandom, $urandom};
        cnt[3:0] = 4'(plan_used);
        write_register(CFG_TYPES_HIGH, hi);
        write_register(CFG_SERVICE_COUNT, cnt);
        write_register(CFG_TYPES_LOW, lo);
    endtask

    // Queue one packet of n bytes; raw packets skip header and checksum building.
    task automatic plan_packet(input int n, input logic [7:0] svc, input logic [5:0] flaws,
                               input bit raw);
        logic [7:0]  pkt [];
        logic [7:0]  hdr [8];
        logic [15:0] len;
        logic [15:0] crc;
        t_in_item    it;
        int          counted;
        pkt = new[n];
        foreach (pkt[k]) pkt[k] = 8'($urandom);
        if (!raw) begin
            counted = (n > int'(COUNT_LIMIT)) ? int'(COUNT_LIMIT) : n;
            len     = 16'(counted - 7);
            if (flaws & FLAW_LENGTH) len = len ^ 16'($urandom_range(1, 65535));
            hdr[0] = {3'b000, 1'($urandom), 1'b1, 3'($urandom)};
            if (flaws & FLAW_VERSION) hdr[0][7:5] = 3'($urandom_range(1, 7));
            if (flaws & FLAW_SEC_FLAG) hdr[0][3] = 1'b0;
            hdr[1] = 8'($urandom);
            hdr[2] = {SEQ_STANDALONE, 6'($urandom)};
            if (flaws & FLAW_SEQUENCE) hdr[2][7:6] = 2'($urandom_range(0, 2));
            hdr[3] = 8'($urandom);
            hdr[4] = len[15:8];
            hdr[5] = len[7:0];
            hdr[6] = {PUS_VERSION, 4'($urandom)};
            if (flaws & FLAW_PUS) begin
                hdr[6][7:4] = 4'($urandom_range(0, 14));
                if (hdr[6][7:4] >= PUS_VERSION) hdr[6][7:4] = hdr[6][7:4] + 4'd1;
            end
            hdr[7] = svc;
            for (int k = 0; k < 8 && k < n; k++) pkt[k] = hdr[k];
            // append the checksum so the residue comes out zero
            if (n >= 10) begin
                crc = CRC_INIT;
                for (int k = 0; k < n - 2; k++) crc = crc_ccitt_step(crc, pkt[k]);
                pkt[n-2] = crc[15:8];
                pkt[n-1] = crc[7:0];
                if (flaws & FLAW_CRC) pkt[n-1] = pkt[n-1] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        for (int k = 0; k < n; k++) begin
            it.data_byte = pkt[k];
            it.last_byte = (k == n - 1);
            byte_plan.push_back(it);
        end
        plan_bytes += n;
        plan_packets++;
    endtask

    function automatic logic [7:0] pick_service();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65 && plan_used > 0) return plan_slots[$urandom_range(0, plan_used - 1)];
        if (r < 80) return plan_slots[$urandom_range(0, MAX_SLOTS - 1)];
        return 8'($urandom);
    endfunction

    function automatic logic [5:0] pick_flaws();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FLAW_NONE;
        if (r < 85) return 6'b000001 << $urandom_range(0, 5);
        return 6'($urandom);
    endfunction

    // Hold until every byte is in and every verdict is out, then let the block settle.
    task automatic settle();
        do @(posedge i_clk);
        while (byte_plan.size() != 0 || i_in_valid || expected_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int          phase;
        int          phase_start;
        int          random_start_bytes;
        int          random_start_packets;
        int          r;
        logic [7:0]  pool [4];

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty routing list straight after reset rejects any service
        plan_packet(MIN_BYTES, 8'h11, FLAW_NONE, 1'b0);
        settle();

        // Four enabled slots with a duplicate; a match only beyond the count
        foreach (plan_slots[s]) plan_slots[s] = 8'h20 + 8'(s);
        plan_slots[0] = 8'h11;
        plan_slots[1] = 8'h03;
        plan_slots[2] = 8'h11;
        plan_slots[3] = 8'h80;
        plan_slots[8] = 8'h42;
        plan_used     = 4;
        commit_routes();
        plan_packet(MIN_BYTES, 8'h03, FLAW_NONE, 1'b0);       // routed, slot 1
        plan_packet(20, 8'h11, FLAW_NONE, 1'b0);              // duplicate, lowest slot
        plan_packet(MIN_BYTES, 8'h42, FLAW_NONE, 1'b0);       // beyond the count
        plan_packet(MIN_BYTES, 8'h03, FLAW_VERSION, 1'b0);
        plan_packet(MIN_BYTES, 8'h03, FLAW_SEC_FLAG, 1'b0);
        plan_packet(MIN_BYTES, 8'h03, FLAW_SEQUENCE, 1'b0);
        plan_packet(MIN_BYTES, 8'h03, FLAW_LENGTH, 1'b0);
        plan_packet(MIN_BYTES, 8'h03, FLAW_PUS, 1'b0);
        plan_packet(MIN_BYTES, 8'h03, FLAW_CRC, 1'b0);
        plan_packet(20, 8'h03, FLAW_VERSION | FLAW_PUS, 1'b0); // header check comes first
        plan_packet(20, 8'h42, FLAW_PUS | FLAW_CRC, 1'b0);     // PUS check before checksum
        plan_packet(20, 8'h42, FLAW_CRC, 1'b0);                // checksum before service
        plan_packet(1, 8'h03, FLAW_NONE, 1'b0);                // single byte
        plan_packet(7, 8'h03, FLAW_NONE, 1'b0);                // no service byte yet
        plan_packet(8, 8'h03, FLAW_NONE, 1'b0);
        plan_packet(MIN_BYTES - 1, 8'h03, FLAW_NONE, 1'b0);    // one short of the minimum
        settle();

        // Longest list (15 enabled slots), extremes of the type byte, junk to the unmapped index
        foreach (plan_slots[s]) plan_slots[s] = 8'h50 + 8'(s);
        plan_slots[0]  = 8'h00;
        plan_slots[8]  = 8'h42;
        plan_slots[14] = 8'hFF;
        plan_slots[15] = 8'hFF;
        plan_used      = 15;
        commit_routes();
        write_register(CFG_UNMAPPED, {$urandom, $urandom});
        plan_packet(MIN_BYTES, 8'h00, FLAW_NONE, 1'b0);
        plan_packet(MIN_BYTES, 8'hFF, FLAW_NONE, 1'b0);        // slot 14, last enabled
        plan_packet(MIN_BYTES, 8'h5F, FLAW_NONE, 1'b0);        // in no slot: slot 15 now holds FF
        settle();

        // Random: mostly well-formed packets under changing routing tables
        random_start_bytes   = plan_bytes;
        random_start_packets = plan_packets;
        phase = 0;
        while (plan_bytes - random_start_bytes < RANDOM_BYTES ||
               plan_packets - random_start_packets < RANDOM_PACKETS) begin
            pool[0] = 8'h00;
            pool[1] = 8'hFF;
            pool[2] = 8'($urandom);
            pool[3] = 8'($urandom);
            foreach (plan_slots[s]) begin
                r = $urandom_range(0, 9);
                plan_slots[s] = (r < 4) ? pool[r] : 8'($urandom);
            end
            case (phase)
                0: begin
                    foreach (plan_slots[s]) plan_slots[s] = 8'h00;
                    plan_used = 15;
                end
                1: begin
                    foreach (plan_slots[s]) plan_slots[s] = 8'hFF;
                    plan_used = 15;
                end
                2: plan_used = 0;
                default: plan_used = ($urandom_range(0, 4) == 0) ? 15 : $urandom_range(1, 14);
            endcase
            commit_routes();
            if ($urandom_range(0, 3) == 0) write_register(CFG_UNMAPPED, {$urandom, $urandom});

            phase_start = plan_bytes;
            while (plan_bytes - phase_start < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    plan_packet($urandom_range(1, 30), 8'h00, FLAW_NONE, 1'b1);
                end else if (r < 13) begin
                    plan_packet($urandom_range(1, MIN_BYTES - 1), pick_service(),
                                pick_flaws(), 1'b0);
                end else if (r < 23) begin
                    plan_packet($urandom_range(25, 120), pick_service(), pick_flaws(), 1'b0);
                end else begin
                    plan_packet($urandom_range(MIN_BYTES, 24), pick_service(), pick_flaws(), 1'b0);
                end
            end
            settle();
            phase++;
        end

        $display("covered %0d packets over %0d bytes and %0d register writes in %0d table phases",
                 checked_count, bytes_accepted, cfg_writes, phase + 3);
        $display({"verdicts: routed %0d, unacceptable %0d, bad app data %0d, ",
                  "bad checksum %0d, unknown service %0d"},
                 verdict_tally[VERDICT_ROUTED], verdict_tally[VERDICT_UNACCEPTABLE],
                 verdict_tally[VERDICT_ILLEGAL_APP], verdict_tally[VERDICT_BAD_CRC],
                 verdict_tally[VERDICT_ILLEGAL_TYPE]);
        if (fail_count == 0) begin
            $display("tc_packet_accept_and_route regression: pass");
        end else begin
            $display("tc_packet_accept_and_route regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(RUN_LIMIT_NS);
        $display("tc_packet_accept_and_route regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/tcpar_pkg.sv
rtl/tcpar_track.sv
rtl/tcpar_route.sv
rtl/tc_packet_accept_and_route.sv
verif/tb_top.sv
